// ===== rtl/core/led_pattern_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// LED pattern sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef LED_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_PATTERN_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define LPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lps: same-cycle check failed");

// next-cycle implication
`define LPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lps: next-cycle check failed");

`endif

// ===== rtl/core/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// LED pattern sequencer package
// Types, register codes, reset values and pattern functions.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef logic [2:0]          pin_t;
  typedef logic [7:0]          led_t;
  typedef logic [CfgDataW-1:0] ticks_t;
  typedef logic [3:0]          step_t;

  typedef enum logic [2:0] {
    MODE_FLASH = 3'd0,
    MODE_SHL   = 3'd1,
    MODE_SHR   = 3'd2,
    MODE_CONV  = 3'd3,
    MODE_DIV   = 3'd4,
    MODE_PING  = 3'd5,
    MODE_SNAKE = 3'd6,
    MODE_COMBO = 3'd7
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FLASH_TICKS = 2'd0,
    CFG_SHIFT_TICKS = 2'd1,
    CFG_PAIR_TICKS  = 2'd2,
    CFG_SNAKE_TICKS = 2'd3
  } cfg_idx_e;

  localparam ticks_t FlashTicksRst = 16'd500;
  localparam ticks_t ShiftTicksRst = 16'd250;
  localparam ticks_t PairTicksRst  = 16'd300;
  localparam ticks_t SnakeTicksRst = 16'd300;

  localparam led_t LedAll  = 8'hFF;
  localparam led_t LedNone = 8'h00;

  typedef struct packed {
    ticks_t flash;
    ticks_t shift;
    ticks_t pair;
    ticks_t snake;
  } cfg_t;

  typedef struct packed {
    led_t  leds;
    mode_e active_mode;
  } result_t;

  function automatic led_t bit_of(input logic [2:0] n);
    bit_of = led_t'(1) << n;
  endfunction

  function automatic led_t conv_pat(input logic [1:0] k);
    conv_pat = bit_of(3'd7 - {1'b0, k}) | bit_of({1'b0, k});
  endfunction

  function automatic led_t div_pat(input logic [1:0] k);
    div_pat = bit_of(3'd4 + {1'b0, k}) | bit_of(3'd3 - {1'b0, k});
  endfunction

  function automatic step_t steps_of(input mode_e m);
    case (m)
      MODE_FLASH:                      steps_of = 4'd2;
      MODE_SHL, MODE_SHR, MODE_SNAKE:  steps_of = 4'd1;
      MODE_CONV, MODE_DIV:             steps_of = 4'd4;
      default:                         steps_of = 4'd8;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lps_if.sv =====
// ----------------------------------------------------------------------------
// LED pattern sequencer channel interfaces
// Valid/ready channels for tick transactions and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface lps_in_if;
  import lps_pkg::*;

  logic valid;
  logic ready;
  pin_t pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

interface lps_out_if;
  import lps_pkg::*;

  logic       valid;
  logic       ready;
  led_t       leds;
  logic [2:0] active_mode;

  modport source (output valid, output leds, output active_mode, input ready);
  modport sink   (input valid, input leds, input active_mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/led_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// LED pattern sequencer
// An accepted tick transaction waits in the input register; when taken, its
// result is loaded into the result register. Throughput: one tick per cycle
// while results are taken; each register refills in the cycle it is emptied.
// Reset: asynchronous, active low; LEDs off, flash mode, no pass running,
// hold counts 500/250/300/300, both channel registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pattern_sequencer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  lps_in_if.sink                             tick_i,
  lps_out_if.source                          result_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [lps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [lps_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import lps_pkg::*;

  `include "led_pattern_sequencer_assert.svh"

  cfg_t    cfg;
  logic    in_vld;
  pin_t    in_pin;
  logic    out_free;
  logic    take;
  result_t res;

  assign take = in_vld && out_free;

  lps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  lps_in_reg u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick_i),
    .take_i (take),
    .vld_o  (in_vld),
    .pin_o  (in_pin)
  );

  lps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .pin_i  (in_pin),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  lps_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (take),
    .res_i    (res),
    .free_o   (out_free),
    .result_o (result_o)
  );

  `LPS_ASSERT_NEXT(a_accept_fills_in, tick_i.valid && tick_i.ready, in_vld)
  `LPS_ASSERT_IMPL(a_stall_blocks_take, result_o.valid && !result_o.ready, !take)
  `LPS_ASSERT_NEXT(a_take_gives_result, take, result_o.valid)

endmodule

`default_nettype wire

// ===== rtl/core/lps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// LED pattern sequencer configuration registers
// Hold counts per mode family, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          we_i,
  input  wire logic [lps_pkg::CfgIdxW-1:0]   idx_i,
  input  wire logic [lps_pkg::CfgDataW-1:0]  wdata_i,
  output lps_pkg::cfg_t                      cfg_o
);
  import lps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_FLASH_TICKS: cfg_d.flash = wdata_i;
        CFG_SHIFT_TICKS: cfg_d.shift = wdata_i;
        CFG_PAIR_TICKS:  cfg_d.pair  = wdata_i;
        CFG_SNAKE_TICKS: cfg_d.snake = wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flash <= FlashTicksRst;
      cfg_q.shift <= ShiftTicksRst;
      cfg_q.pair  <= PairTicksRst;
      cfg_q.snake <= SnakeTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/lps_in_reg.sv =====
// ----------------------------------------------------------------------------
// LED pattern sequencer input register
// Captures one tick transaction; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  lps_in_if.sink          tick_i,
  input  wire logic       take_i,
  output logic            vld_o,
  output lps_pkg::pin_t   pin_o
);
  import lps_pkg::*;

  logic vld_q, vld_d;
  pin_t pin_q;
  logic load;

  assign tick_i.ready = !vld_q || take_i;
  assign load         = tick_i.valid && tick_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pin_q <= tick_i.pin_levels;
    end
  end

  assign vld_o = vld_q;
  assign pin_o = pin_q;

endmodule

`default_nettype wire

// ===== rtl/core/lps_core.sv =====
// ----------------------------------------------------------------------------
// LED pattern sequencer core
// Pass state, step patterns and hold counting, one tick per take.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  lps_pkg::pin_t   pin_i,
  input  lps_pkg::cfg_t   cfg_i,
  output lps_pkg::result_t res_o
);
  import lps_pkg::*;

  mode_e      mode_q, mode_d;
  logic       busy_q, busy_d;
  step_t      step_q, step_d;
  ticks_t     tick_q, tick_d;
  logic [2:0] shift_q, shift_d;
  logic [2:0] snake_q, snake_d;
  logic       pp_q, pp_d;
  led_t       led_q, led_d;

  mode_e  mode;
  step_t  step;
  ticks_t tick;
  ticks_t hold_raw;
  ticks_t hold;
  ticks_t tick_inc;
  step_t  step_nxt;
  led_t   pat;
  led_t   led_cur;

  assign mode = busy_q ? mode_q : mode_e'(~pin_i);
  assign step = busy_q ? step_q : 4'd0;
  assign tick = busy_q ? tick_q : '0;

  always_comb begin
    case (mode)
      MODE_FLASH:                    hold_raw = cfg_i.flash;
      MODE_SHL, MODE_SHR, MODE_PING: hold_raw = cfg_i.shift;
      MODE_SNAKE:                    hold_raw = cfg_i.snake;
      default:                       hold_raw = cfg_i.pair;
    endcase
  end

  assign hold = (hold_raw == '0) ? ticks_t'(1) : hold_raw;

  always_comb begin
    case (mode)
      MODE_FLASH:         pat = (step == 4'd0) ? LedAll : LedNone;
      MODE_SHL, MODE_SHR: pat = bit_of(shift_q);
      MODE_CONV:          pat = conv_pat(step[1:0]);
      MODE_DIV:           pat = div_pat(step[1:0]);
      MODE_PING:          pat = pp_q ? bit_of(3'd7 - step[2:0]) : bit_of(step[2:0]);
      MODE_SNAKE:         pat = led_q | bit_of(snake_q);
      default:            pat = step[2] ? div_pat(step[1:0]) : conv_pat(step[1:0]);
    endcase
  end

  assign led_cur  = (tick == '0) ? pat : led_q;
  assign tick_inc = tick + ticks_t'(1);
  assign step_nxt = step + 4'd1;

  always_comb begin
    mode_d  = mode;
    busy_d  = 1'b1;
    step_d  = step;
    tick_d  = tick_inc;
    shift_d = shift_q;
    snake_d = snake_q;
    pp_d    = pp_q;
    led_d   = led_cur;
    if (tick_inc >= hold) begin
      tick_d = '0;
      step_d = step_nxt;
      if (step_nxt >= steps_of(mode)) begin
        step_d = 4'd0;
        busy_d = 1'b0;
        case (mode)
          MODE_SHL:   shift_d = shift_q + 3'd1;
          MODE_SHR:   shift_d = shift_q - 3'd1;
          MODE_PING:  pp_d = !pp_q;
          MODE_SNAKE: begin
            snake_d = snake_q + 3'd1;
            if (snake_q == 3'd7) begin
              led_d = LedNone;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_FLASH;
      busy_q  <= 1'b0;
      step_q  <= '0;
      tick_q  <= '0;
      shift_q <= '0;
      snake_q <= '0;
      pp_q    <= 1'b0;
      led_q   <= '0;
    end else if (take_i) begin
      mode_q  <= mode_d;
      busy_q  <= busy_d;
      step_q  <= step_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      snake_q <= snake_d;
      pp_q    <= pp_d;
      led_q   <= led_d;
    end
  end

  assign res_o.leds        = led_cur;
  assign res_o.active_mode = mode;

endmodule

`default_nettype wire

// ===== rtl/core/lps_out_reg.sv =====
// ----------------------------------------------------------------------------
// LED pattern sequencer result register
// Holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_out_reg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_i,
  input  lps_pkg::result_t  res_i,
  output logic              free_o,
  lps_out_if.source         result_o
);
  import lps_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  assign free_o = !vld_q || result_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (result_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign result_o.valid       = vld_q;
  assign result_o.leds        = res_q.leds;
  assign result_o.active_mode = res_q.active_mode;

endmodule

`default_nettype wire
